// File: sv/note_tone_synthesizer_top_assert.svh
// Assertion macros used by the RTL of the tone synthesizer.
`ifndef NOTE_TONE_SYNTHESIZER_TOP_ASSERT_SVH
`define NOTE_TONE_SYNTHESIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/nts_pkg.sv
`default_nettype none

package nts_pkg;

    // The sine table depth is a power of two.
    localparam int SINE_DEPTH = 1024;
    localparam int PHASE_BITS = 32;

    localparam int IDX_BITS = $clog2(SINE_DEPTH);
    localparam int RR_W = IDX_BITS + 1;
    localparam logic [RR_W-1:0] DEPTH_RR = RR_W'(SINE_DEPTH);

    localparam int Q_FRAC = 30;
    localparam int T_W = Q_FRAC + 1;
    localparam int MUL_W = 32;

    localparam int FC_W = 15;
    localparam int SR_W = 17;
    localparam int DEN_W = 24;
    localparam int NUM_W = FC_W + PHASE_BITS;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam int SL_W = 17;
    localparam int AMP_W = 15;
    localparam int LEVEL_W = 6;
    localparam int ENTRY_W = 15;
    localparam int SAMPLE_W = 16;

    localparam logic [SR_W-1:0] SAMPLE_RATE_RESET = SR_W'(44100);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] DUR_QUARTER = 2'd0;
    localparam logic [1:0] DUR_EIGHTH = 2'd1;

    localparam logic [2:0] HORNER_LAST = 3'd4;
    localparam logic [2:0] HORNER_TOP = 3'd5;

    typedef struct packed {
        logic            start;
        logic [FC_W-1:0] fc;
        logic [SR_W-1:0] sr;
    } nts_div_req_t;

    typedef struct packed {
        logic                  done;
        logic [PHASE_BITS-1:0] step;
    } nts_div_rsp_t;

    // Pitch frequency in hundredths of a hertz.
    function automatic logic [FC_W-1:0] pitch_centihz(input logic [2:0] p);
        logic [FC_W-1:0] f;
        unique case (p)
            3'd0: f = FC_W'(13081);
            3'd1: f = FC_W'(14683);
            3'd2: f = FC_W'(16481);
            3'd3: f = FC_W'(17461);
            3'd4: f = FC_W'(19600);
            3'd5: f = FC_W'(22000);
            default: f = FC_W'(24694);
        endcase
        return f;
    endfunction

    // Magnitudes of the Taylor coefficients of sin(pi/2 * t) in Q30.
    function automatic logic [T_W-1:0] sine_coef(input logic [2:0] k);
        logic [T_W-1:0] c;
        unique case (k)
            3'd0: c = T_W'(1686629713);
            3'd1: c = T_W'(693598668);
            3'd2: c = T_W'(85569306);
            3'd3: c = T_W'(5026995);
            3'd4: c = T_W'(172273);
            3'd5: c = T_W'(3864);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/nts_div.sv
`default_nettype none

module nts_div (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire nts_pkg::nts_div_req_t req,
    output nts_pkg::nts_div_rsp_t rsp
);

    logic [nts_pkg::NUM_W-1:0]     quo_reg;
    logic [nts_pkg::DEN_W-1:0]     rem_reg;
    logic [nts_pkg::DEN_W-1:0]     den_reg;
    logic [nts_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [nts_pkg::NUM_W-1:0] num_start;
    logic [nts_pkg::DEN_W-1:0] den_start;
    logic [nts_pkg::DEN_W:0]   trial;
    logic [nts_pkg::DEN_W:0]   diff;
    logic                      ge;
    logic [nts_pkg::DEN_W-1:0] rem_next;
    logic [nts_pkg::NUM_W-1:0] quo_next;

    // The rounding term 50 * sr is added to fc * 2^PHASE_BITS.
    assign num_start = {req.fc, {nts_pkg::PHASE_BITS{1'b0}}}
                     + nts_pkg::NUM_W'(23'(req.sr) * 23'd50);
    assign den_start = nts_pkg::DEN_W'(req.sr) * nts_pkg::DEN_W'(100);

    assign trial    = {rem_reg, quo_reg[nts_pkg::NUM_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? diff[nts_pkg::DEN_W-1:0] : trial[nts_pkg::DEN_W-1:0];
    assign quo_next = {quo_reg[nts_pkg::NUM_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (req.start)
            begin
                quo_reg  <= num_start;
                rem_reg  <= '0;
                den_reg  <= den_start;
                cnt_reg  <= nts_pkg::DIV_CNT_W'(nts_pkg::NUM_W);
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == nts_pkg::DIV_CNT_W'(1));
                if (cnt_reg == nts_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.step = quo_reg[nts_pkg::PHASE_BITS-1:0];

endmodule

`default_nettype wire

// File: sv/note_tone_synthesizer_top.sv
// Channel  Dir  Handshake              Word
// in       in   in_valid / in_ready    operation, duration_code, pitch, level
// out      out  out_valid / out_ready  sample, note_last, idle
// cfg      in   cfg_valid / cfg_ready  cfg_data (sample_rate)
//
// A note load waits on the restoring divider (one quotient bit a cycle).
// A tick of a playing note runs through the one shared 32 x 32 multiplier.
// A tick while idle goes straight to S_DONE. in_ready is high only while the sequencer is idle.
// A finished word waits in the output register while the next word is accepted.
// Reset is asynchronous: the sample rate returns to 44100 and no note is playing.
`default_nettype none

module note_tone_synthesizer_top (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 operation,
    input  wire  [1:0]                          duration_code,
    input  wire  [2:0]                          pitch,
    input  wire  [nts_pkg::LEVEL_W-1:0]         level,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [nts_pkg::SAMPLE_W-1:0] sample,
    output logic                                note_last,
    output logic                                idle,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [nts_pkg::SR_W-1:0]            cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SQ,
        S_HORNER,
        S_FINAL,
        S_SCALE,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [nts_pkg::SR_W-1:0]       sample_rate_reg;
    logic [nts_pkg::PHASE_BITS-1:0] phase_reg;
    logic [nts_pkg::PHASE_BITS-1:0] step_reg;
    logic [nts_pkg::SL_W-1:0]       samples_left_reg;
    logic [nts_pkg::AMP_W-1:0]      amp_reg;
    logic                           playing_reg;

    logic [nts_pkg::T_W-1:0]     t_reg;
    logic [nts_pkg::T_W-1:0]     t2_reg;
    logic [nts_pkg::T_W-1:0]     acc_reg;
    logic [2:0]                  k_reg;
    logic [nts_pkg::ENTRY_W-1:0] entry_reg;
    logic                        neg_reg;

    logic [nts_pkg::SAMPLE_W-1:0] res_sample_reg;
    logic                         res_last_reg;
    logic                         res_idle_reg;

    logic                         out_valid_reg;
    logic [nts_pkg::SAMPLE_W-1:0] sample_reg;
    logic                         note_last_reg;
    logic                         idle_reg;

    logic                      in_accept;
    logic                      out_load;
    logic [nts_pkg::SR_W-1:0]  sr_eff;
    logic [nts_pkg::SL_W-1:0]  note_len;
    logic [15:0]               amp_raw;
    logic [nts_pkg::AMP_W-1:0] amp_sat;

    logic [nts_pkg::IDX_BITS+1:0] idx;
    logic [nts_pkg::RR_W-1:0]     rr;
    logic [nts_pkg::SL_W-1:0]     left_next;

    logic [nts_pkg::MUL_W-1:0]   mul_a;
    logic [nts_pkg::MUL_W-1:0]   mul_b;
    logic [2*nts_pkg::MUL_W-1:0] mul_p;
    logic [nts_pkg::T_W-1:0]     mul_q;

    logic [16:0]                  entry_rnd;
    logic [nts_pkg::ENTRY_W-1:0]  entry_sat;
    logic [nts_pkg::SAMPLE_W-1:0] mag;

    nts_pkg::nts_div_req_t div_req;
    nts_pkg::nts_div_rsp_t div_rsp;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign sr_eff = (sample_rate_reg == '0) ? nts_pkg::SR_W'(1) : sample_rate_reg;

    always_comb
    begin
        priority if (duration_code == nts_pkg::DUR_QUARTER)
            note_len = sr_eff;
        else if (duration_code == nts_pkg::DUR_EIGHTH)
            note_len = nts_pkg::SL_W'((18'(sr_eff) + 18'd1) >> 1);
        else
            note_len = nts_pkg::SL_W'((18'(sr_eff) + 18'd3) >> 2);
    end

    assign amp_raw = 16'(level) * 16'd1000;
    assign amp_sat = (amp_raw > 16'd32767) ? '1 : amp_raw[nts_pkg::AMP_W-1:0];

    assign idx = phase_reg[nts_pkg::PHASE_BITS-1 -: nts_pkg::IDX_BITS+2];
    assign rr  = idx[nts_pkg::IDX_BITS]
               ? nts_pkg::DEPTH_RR - {1'b0, idx[nts_pkg::IDX_BITS-1:0]}
               : {1'b0, idx[nts_pkg::IDX_BITS-1:0]};
    assign left_next = samples_left_reg - 1'b1;

    assign div_req.start = in_accept && (operation == nts_pkg::OP_LOAD);
    assign div_req.fc    = nts_pkg::pitch_centihz(pitch);
    assign div_req.sr    = sr_eff;

    nts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = nts_pkg::MUL_W'(t_reg);
                mul_b = nts_pkg::MUL_W'(t_reg);
            end
            S_HORNER:
            begin
                mul_a = nts_pkg::MUL_W'(t2_reg);
                mul_b = nts_pkg::MUL_W'(acc_reg);
            end
            S_FINAL:
            begin
                mul_a = nts_pkg::MUL_W'(t_reg);
                mul_b = nts_pkg::MUL_W'(acc_reg);
            end
            S_SCALE:
            begin
                mul_a = nts_pkg::MUL_W'(amp_reg);
                mul_b = nts_pkg::MUL_W'(entry_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign mul_q = mul_p[nts_pkg::Q_FRAC+nts_pkg::T_W-1:nts_pkg::Q_FRAC];

    assign entry_rnd = 17'((32'(mul_q) + 32'd16384) >> 15);
    assign entry_sat = (entry_rnd > 17'd32767) ? '1 : entry_rnd[nts_pkg::ENTRY_W-1:0];
    assign mag       = nts_pkg::SAMPLE_W'((31'(mul_p[29:0]) + 31'd16384) >> 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sample_rate_reg  <= nts_pkg::SAMPLE_RATE_RESET;
            phase_reg        <= '0;
            step_reg         <= '0;
            samples_left_reg <= '0;
            amp_reg          <= '0;
            playing_reg      <= 1'b0;
            k_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sample_rate_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                sample_reg    <= res_sample_reg;
                note_last_reg <= res_last_reg;
                idle_reg      <= res_idle_reg;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (operation == nts_pkg::OP_LOAD)
                        begin
                            samples_left_reg <= note_len;
                            amp_reg          <= amp_sat;
                            phase_reg        <= '0;
                            playing_reg      <= 1'b1;
                            state_reg        <= S_DIV;
                        end
                        else if (!playing_reg)
                        begin
                            res_sample_reg <= '0;
                            res_last_reg   <= 1'b0;
                            res_idle_reg   <= 1'b1;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            t_reg <= nts_pkg::T_W'(rr) << (nts_pkg::Q_FRAC - nts_pkg::IDX_BITS);
                            neg_reg          <= idx[nts_pkg::IDX_BITS+1];
                            phase_reg        <= phase_reg + step_reg;
                            samples_left_reg <= left_next;
                            playing_reg      <= (left_next != '0);
                            res_last_reg     <= (left_next == '0);
                            res_idle_reg     <= 1'b0;
                            state_reg        <= S_SQ;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        step_reg  <= div_rsp.step;
                        state_reg <= S_IDLE;
                    end
                end
                S_SQ:
                begin
                    t2_reg    <= mul_q;
                    acc_reg   <= nts_pkg::sine_coef(nts_pkg::HORNER_TOP);
                    k_reg     <= nts_pkg::HORNER_LAST;
                    state_reg <= S_HORNER;
                end
                S_HORNER:
                begin
                    acc_reg <= nts_pkg::sine_coef(k_reg) - mul_q;
                    if (k_reg == '0)
                    begin
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                S_FINAL:
                begin
                    entry_reg <= entry_sat;
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    res_sample_reg <= neg_reg ? nts_pkg::SAMPLE_W'(16'd0 - mag) : mag;
                    state_reg      <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign note_last = note_last_reg;
    assign idle      = idle_reg;

`include "note_tone_synthesizer_top_assert.svh"

    `NTS_ASSERT_SAME(a_idle_word_zero, out_valid_reg && idle_reg,
        sample_reg == '0 && !note_last_reg, "idle word carries a nonzero sample")
    `NTS_ASSERT_SAME(a_div_done_in_div, div_rsp.done,
        state_reg == S_DIV, "divider finished outside the load sequence")
    `NTS_ASSERT_NEXT(a_tick_starts_poly,
        in_accept && operation == nts_pkg::OP_TICK && playing_reg,
        state_reg == S_SQ, "playing tick did not start the sine evaluation")
    `NTS_ASSERT_SAME(a_horner_range, state_reg == S_HORNER,
        k_reg <= nts_pkg::HORNER_LAST, "Horner step index out of range")

endmodule

`default_nettype wire
